[design/lru_key_value_cache_core_defines.svh]
// assertion macros shared by the lru key/value cache rtl
// no dependencies; included by the files that carry assertions
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// clocked assertion, masked while reset is high
`define LKV_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LKV_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lkv_pkg.sv]
// shared types and constants of the lru key/value cache
// no dependencies; imported by every module of the block but lkv_ram
`timescale 1ns / 1ps

package lkv_pkg;

  // storage geometry
  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 32;
  localparam int KEY_FIELD_W = 32;
  localparam int DATA_W      = 64;
  localparam int STAMP_W     = 64;
  localparam int CAP_W       = 5;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);

  // stream payload widths
  localparam int S_TDATA_W = KEY_FIELD_W + DATA_W;
  localparam int M_TDATA_W = DATA_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation codes carried in s_tuser
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RDWAIT,
    ST_RESPOND
  } lkv_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_op;
    logic scan_en;
    logic commit;
    logic capture_rd;
    logic respond;
  } lkv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic get_hit;
    logic out_busy;
  } lkv_status_t;

endpackage

[design/lkv_ram.sv]
// generic single write port ram with one registered read port
// no dependencies; used for the key, data and stamp stores
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/lkv_ctrl.sv]
// request sequencer of the lru key/value cache
// depends on lkv_pkg; drives the command struct of lkv_datapath
`timescale 1ns / 1ps

module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  lkv_status_t status,
  output lkv_cmd_t    cmd
);

  lkv_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = status.get_hit ? ST_RDWAIT : ST_RESPOND;
      end
      ST_RDWAIT: begin
        state_next = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_op = s_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        cmd.commit = 1'b1;
      end
      ST_RDWAIT: begin
        cmd.capture_rd = 1'b1;
      end
      ST_RESPOND: begin
        cmd.respond = !status.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/lkv_datapath.sv]
// stores, entry scan, replacement choice and result register of the cache
// depends on lkv_pkg, lkv_ram and the assertion macro header
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_defines.svh"

module lkv_datapath
  import lkv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  input  lkv_cmd_t             cmd,
  output lkv_status_t          status
);

  // configuration and persistent state
  logic [CAP_W-1:0]   cap_reg;
  logic [CNT_W-1:0]   cap_eff;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   occ;
  logic [STAMP_W-1:0] use_counter;
  logic [STAMP_W-1:0] stamp_new;

  // latched request
  logic                op_mode;
  logic [KEY_BITS-1:0] op_key;
  logic [DATA_W-1:0]   op_wdata;

  // scan pipeline and trackers
  logic [IDX_W-1:0]   scan_idx;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               min_found;
  logic [IDX_W-1:0]   min_idx;
  logic [STAMP_W-1:0] min_stamp;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  // ram ports
  logic [KEY_BITS-1:0] key_q;
  logic [STAMP_W-1:0]  stamp_q;
  logic [DATA_W-1:0]   data_q;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic                key_we;
  logic                data_we;
  logic                stamp_we;

  // replacement decision
  logic               is_put;
  logic               need_evict;
  logic               do_evict;
  logic [IDX_W-1:0]   slot;
  logic               ins_new;
  logic [ENTRIES-1:0] valid_next;

  // result
  logic              res_hit;
  logic [DATA_W-1:0] res_data;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_data;
    end
  end

  // zero behaves as one, large values saturate at the entry count
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_reg) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_reg);
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_mode  <= s_tuser;
      op_key   <= s_tdata[KEY_BITS-1:0];
      op_wdata <= s_tdata[KEY_FIELD_W +: DATA_W];
    end
  end

  // scan address and compare stage tag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_en;
      if (cmd.load_op) begin
        scan_idx <= '0;
      end else if (cmd.scan_en) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
  end

  // key match, oldest valid entry and lowest free slot, one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      match_found <= 1'b0;
      min_found   <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmp_valid) begin
      if (valid[cmp_idx] && key_q == op_key && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
      end
      if (valid[cmp_idx] && (!min_found || stamp_q < min_stamp)) begin
        min_found <= 1'b1;
        min_idx   <= cmp_idx;
        min_stamp <= stamp_q;
      end
      if (!valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  // replacement choice for a store of a new key
  always_comb begin
    is_put     = (op_mode == MODE_PUT);
    need_evict = (occ >= cap_eff) || !free_found;
    do_evict   = need_evict && min_found;
    if (do_evict && (!free_found || min_idx < free_idx)) begin
      slot = min_idx;
    end else begin
      slot = free_idx;
    end
    valid_next = valid;
    if (do_evict) begin
      valid_next[min_idx] = 1'b0;
    end
    valid_next[slot] = 1'b1;
    ins_new   = cmd.commit && is_put && !match_found;
    stamp_new = use_counter + STAMP_W'(1);
    rd_idx    = cmd.scan_en ? scan_idx : match_idx;
    wr_idx    = match_found ? match_idx : slot;
    key_we    = ins_new;
    data_we   = cmd.commit && is_put;
    stamp_we  = cmd.commit && (is_put || match_found);
  end

  // valid bits, occupancy and use counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      occ         <= '0;
      use_counter <= '0;
    end else begin
      if (stamp_we) begin
        use_counter <= stamp_new;
      end
      if (ins_new) begin
        valid <= valid_next;
        occ <= do_evict ? occ : occ + CNT_W'(1);
      end
    end
  end

  // stores
  lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_idx),
    .wdata (op_key),
    .raddr (rd_idx),
    .rdata (key_q)
  );

  lkv_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_idx),
    .wdata (op_wdata),
    .raddr (rd_idx),
    .rdata (data_q)
  );

  lkv_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_idx),
    .wdata (stamp_new),
    .raddr (rd_idx),
    .rdata (stamp_q)
  );

  // result assembly
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_hit  <= match_found;
      res_data <= '0;
    end else if (cmd.capture_rd) begin
      res_data <= data_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.respond) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      m_tdata <= res_data;
      m_tuser <= res_hit;
    end
  end

  // status to the sequencer
  always_comb begin
    status.scan_last = (scan_idx == IDX_W'(ENTRIES - 1));
    status.get_hit   = (op_mode == MODE_GET) && match_found;
    status.out_busy  = m_tvalid && !m_tready;
  end

  // checks
  `LKV_ASSERT(a_occ_matches_valid, clk, rst, $countones(valid) == int'(occ), "occupancy count disagrees with valid bits")
  `LKV_ASSERT(a_occ_bounded, clk, rst, int'(occ) <= ENTRIES, "occupancy above entry count")
  `LKV_ASSERT(a_insert_slot_free, clk, rst, ins_new |-> (!valid[slot] || (do_evict && slot == min_idx)), "new key stored over a live entry")
  `LKV_ASSERT(a_counter_moves_on_commit, clk, rst, (!$past(rst) && use_counter != $past(use_counter)) |-> $past(cmd.commit), "use counter moved outside a commit")
  `LKV_ASSERT(a_result_after_respond, clk, rst, (!$past(rst) && $rose(m_tvalid)) |-> $past(cmd.respond), "result shown without a respond command")

endmodule

[design/lru_key_value_cache_core.sv]
// Fully associative key/value cache with least recently used replacement.
// Each request (get or put) is taken in the idle step and then passes
// the scan, drain and decide steps, a read wait step on a get hit only,
// and the respond step that loads the output register. A new request is
// taken only back in the idle step. The pace is set by the entry scan,
// which reads one key and one stamp per cycle through the single read port
// of the stores and finds the matching key, the oldest entry and the lowest
// free slot in the same pass. A new request is taken while the previous
// result still waits in the output register. A stalled result side holds
// the sequencer in its respond step until the output register frees.
// Capacity may be written only while the block is idle.
// depends on lkv_pkg, lkv_ctrl and lkv_datapath
`timescale 1ns / 1ps

module lru_key_value_cache_core
  import lkv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // lookup_key [31:0], write_data [95:32]
  input  logic                 s_tuser,   // mode: 0 get, 1 put
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // read_data [63:0]
  output logic                 m_tuser,   // hit
  // capacity register
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_data
);

  lkv_cmd_t    cmd;
  lkv_status_t status;

  // sequencer
  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // stores and scan logic
  lkv_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

[tb/sv/lru_key_value_cache_core_tb.sv]
// self-checking testbench for the lru key/value cache: directed table, then random phases
// depends on lkv_pkg and lru_key_value_cache_core; results checked against an inline cache model
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb
  import lkv_pkg::*;
();

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_ITEMS = 105;
  localparam logic [KEY_FIELD_W-1:0] KEY_MASK = {KEY_BITS{1'b1}};

  typedef struct {
    logic              hit;
    logic [DATA_W-1:0] rdata;
  } cache_answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   mode;
    logic [KEY_FIELD_W-1:0] key;
    logic [DATA_W-1:0]      wdata;
    logic [CAP_W-1:0]       cap;
    bit                     typed;
    cache_answer_t          answer;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = MODE_GET;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CAP_W-1:0]     cfg_data = '0;

  // cache model state
  logic [KEY_FIELD_W-1:0] ent_key   [ENTRIES];
  logic [DATA_W-1:0]      ent_data  [ENTRIES];
  logic [STAMP_W-1:0]     ent_stamp [ENTRIES];
  bit                     ent_valid [ENTRIES];
  logic [STAMP_W-1:0]     use_count = '0;
  int                     occupancy = 0;
  logic [CAP_W-1:0]       cap_reg = CAP_RESET;

  cache_answer_t answer_q[$];
  table_row_t    directed_rows[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            rx_wait = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;

  lru_key_value_cache_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // oldest valid entry goes; ties keep the lowest index
  function automatic void evict_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (ent_valid[i] && (victim < 0 || ent_stamp[i] < ent_stamp[victim])) victim = i;
    if (victim >= 0) begin
      ent_valid[victim] = 1'b0;
      if (occupancy > 0) occupancy--;
    end
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < ENTRIES; i++)
      if (!ent_valid[i]) return i;
    return -1;
  endfunction

  // applies one request to the cache model and returns the answer it gives
  function automatic cache_answer_t cache_access(input logic mode,
                                                 input logic [KEY_FIELD_W-1:0] key_in,
                                                 input logic [DATA_W-1:0] wdata);
    cache_answer_t          ans;
    logic [KEY_FIELD_W-1:0] key;
    int                     cap;
    int                     slot;
    ans.hit = 1'b0;
    ans.rdata = '0;
    key = key_in & KEY_MASK;
    cap = int'(cap_reg);
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && ent_valid[i] && ent_key[i] == key) slot = i;
    if (mode == MODE_GET) begin
      if (slot >= 0) begin
        use_count = use_count + 1'b1;
        ent_stamp[slot] = use_count;
        ans.hit = 1'b1;
        ans.rdata = ent_data[slot];
      end
    end else if (slot >= 0) begin
      ent_data[slot] = wdata;
      use_count = use_count + 1'b1;
      ent_stamp[slot] = use_count;
      ans.hit = 1'b1;
    end else begin
      if (occupancy >= cap) evict_oldest();
      slot = lowest_free();
      if (slot < 0) begin
        evict_oldest();
        slot = lowest_free();
      end
      if (slot >= 0) begin
        ent_key[slot] = key;
        ent_data[slot] = wdata;
        use_count = use_count + 1'b1;
        ent_stamp[slot] = use_count;
        ent_valid[slot] = 1'b1;
        occupancy++;
      end
    end
    return ans;
  endfunction

  // drive one request after a random gap; valid stays high for back-to-back requests
  task automatic send_request(input logic mode, input logic [KEY_FIELD_W-1:0] key,
                              input logic [DATA_W-1:0] wdata, input bit typed,
                              input cache_answer_t typed_ans);
    int            gap;
    cache_answer_t ans;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {wdata, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ans = cache_access(mode, key, wdata);
    if (typed) ans = typed_ans;
    answer_q.insert(answer_q.size(), ans);
  endtask

  // drain every outstanding result, let the block settle, then write capacity
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    s_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = value;
  endtask

  function automatic void add_req(input logic mode, input logic [KEY_FIELD_W-1:0] key,
                                  input logic [DATA_W-1:0] wdata, input bit typed = 1'b0,
                                  input logic hit = 1'b0, input logic [DATA_W-1:0] rdata = '0);
    table_row_t row;
    row.kind = ROW_REQ;
    row.mode = mode;
    row.key = key;
    row.wdata = wdata;
    row.cap = '0;
    row.typed = typed;
    row.answer.hit = hit;
    row.answer.rdata = rdata;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_cfg(input logic [CAP_W-1:0] value);
    table_row_t row;
    row.kind = ROW_CFG;
    row.mode = MODE_GET;
    row.key = '0;
    row.wdata = '0;
    row.cap = value;
    row.typed = 1'b0;
    row.answer.hit = 1'b0;
    row.answer.rdata = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // result side: random stall drawn after every accepted result
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else if (m_tvalid && m_tready) begin
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
      m_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      m_tready <= (rx_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result with the oldest outstanding answer
  always @(posedge clk) begin : check_results
    cache_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (answer_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result hit=%0b data=%h", m_tuser, m_tdata));
      end else begin
        want = answer_q.pop_front();
        if (m_tuser !== want.hit)
          flag_mismatch($sformatf("hit %0b, want %0b", m_tuser, want.hit));
        if (m_tdata !== want.rdata)
          flag_mismatch($sformatf("read_data %h, want %h", m_tdata, want.rdata));
      end
    end
  end

  initial begin : stimulus
    logic [KEY_FIELD_W-1:0] key_pool [32];
    int                     pool_n;
    int                     eff_cap;
    int                     pick;
    logic [CAP_W-1:0]       cap_val;
    logic [KEY_FIELD_W-1:0] key;
    logic                   mode;
    cache_answer_t          none;
    logic [CAP_W-1:0]       early_caps [8];

    early_caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd15, 5'd3};
    none.hit = 1'b0;
    none.rdata = '0;
    foreach (ent_valid[i]) begin
      ent_valid[i] = 1'b0;
      ent_key[i] = '0;
      ent_data[i] = '0;
      ent_stamp[i] = '0;
    end

    // empty cache, extreme keys and data, overwrite of a present key
    add_req(MODE_GET, 32'h0000_0000, 64'h0, 1'b1, 1'b0, 64'h0);
    add_req(MODE_PUT, 32'h0000_0000, 64'h0, 1'b1, 1'b0, 64'h0);
    add_req(MODE_PUT, 32'hFFFF_FFFF, {DATA_W{1'b1}}, 1'b1, 1'b0, 64'h0);
    add_req(MODE_GET, 32'hFFFF_FFFF, 64'h0, 1'b1, 1'b1, {DATA_W{1'b1}});
    add_req(MODE_GET, 32'h0000_0000, {DATA_W{1'b1}}, 1'b1, 1'b1, 64'h0);
    add_req(MODE_PUT, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 64'h0);
    add_req(MODE_GET, 32'hFFFF_FFFF, 64'h0, 1'b1, 1'b1, 64'h5555_5555_5555_5555);
    add_req(MODE_GET, 32'h1234_5678, 64'h0, 1'b1, 1'b0, 64'h0);
    add_req(MODE_PUT, 32'h0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 64'h0);
    add_req(MODE_PUT, 32'h8000_0000, 64'h0000_0000_0000_0001);
    // capacity lowered below occupancy: one eviction per new key
    add_cfg(5'd1);
    add_req(MODE_PUT, 32'h0000_0011, 64'h1111_0000_1111_0000);
    add_req(MODE_GET, 32'h0000_0000, 64'h0);
    add_req(MODE_GET, 32'h0000_0011, 64'h0);
    add_req(MODE_PUT, 32'h0000_0022, 64'h2222_2222_0000_0000);
    // capacity zero acts as one
    add_cfg(5'd0);
    add_req(MODE_PUT, 32'h0000_0033, 64'h3333_3333_3333_3333);
    add_req(MODE_GET, 32'h0000_0022, 64'h0);
    // capacity above the entry count saturates
    add_cfg(5'd31);
    add_req(MODE_PUT, 32'hA5A5_A5A5, 64'hDEAD_BEEF_0123_4567);
    add_req(MODE_PUT, 32'h5A5A_5A5A, 64'h8000_0000_0000_0000);
    add_req(MODE_GET, 32'hFFFF_FFFF, 64'h0);
    add_req(MODE_PUT, 32'h0000_0033, 64'h0F0F_0F0F_0F0F_0F0F);
    add_req(MODE_GET, 32'h0000_0033, 64'h0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        set_capacity(directed_rows[r].cap);
      else
        send_request(directed_rows[r].mode, directed_rows[r].key, directed_rows[r].wdata,
                     directed_rows[r].typed, directed_rows[r].answer);
    end

    // random phases: keys mostly from a working set sized around the capacity
    for (int p = 0; p < RAND_PHASES; p++) begin
      cap_val = (p < 8) ? early_caps[p] : CAP_W'($urandom_range(0, 31));
      set_capacity(cap_val);
      eff_cap = (cap_val == 0) ? 1 : ((cap_val > ENTRIES) ? ENTRIES : int'(cap_val));
      pool_n = eff_cap + $urandom_range(1, 8);
      if (pool_n > 32) pool_n = 32;
      for (int k = 0; k < pool_n; k++) key_pool[k] = $urandom;
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75)
          key = key_pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 90)
          key = $urandom;
        else if (pick < 95)
          key = key_pool[$urandom_range(0, pool_n - 1)] ^ (32'h1 << $urandom_range(0, 31));
        else
          key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        mode = ($urandom_range(0, 99) < 45) ? MODE_PUT : MODE_GET;
        send_request(mode, key, {$urandom, $urandom}, 1'b0, none);
      end
    end

    // drain and finish
    s_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && answer_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
